// ===== design/lfms_pkg.sv =====
// ----------------------------------------------------------------------------
// lfms_pkg
// shared widths, types, register codes and helpers for the foot motion step
// ----------------------------------------------------------------------------
package lfms_pkg;

  localparam int COORD_WIDTH = 20;
  localparam int TIME_W      = 20;
  localparam int REG_W       = 16;
  localparam int PROD_W      = REG_W + TIME_W;
  localparam int MOVE_W      = 17;
  localparam int US_PER_S    = 1000000;

  // floor(p / 10^6) = floor(floor(p / 64) * US_RCP / 2^44), exact for p below 2^36
  localparam int                US_SH     = 6;
  localparam int                US_RCP_W  = 31;
  localparam logic [US_RCP_W-1:0] US_RCP  = 31'd1125899907;
  localparam int                US_RCP_K  = 44;
  localparam int                RCP_PW    = PROD_W - US_SH + US_RCP_W;

  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int MAG_W   = COORD_WIDTH;
  localparam int DIST_W  = COORD_WIDTH + 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int NSTEP   = (DIST_W > MOVE_W) ? DIST_W : MOVE_W;
  localparam int RAD_W   = 2 * NSTEP;
  localparam int LIFT_SW = ((DIFF_W > REG_W + 1) ? DIFF_W : REG_W + 1) + 1;
  localparam int LIFT_AW = LIFT_SW - 1;
  localparam int UP_W    = LIFT_AW + REG_W + 1;
  localparam int RUN_W   = DIST_W + REG_W;
  localparam int HN_W    = 2 * REG_W + DIST_W;
  localparam int PX_W    = MAG_W + MOVE_W;
  localparam int NUM_W   = HN_W;
  localparam int DEN_W   = UP_W;
  localparam int REM_W   = (NUM_W > DEN_W + NSTEP) ? NUM_W : DEN_W + NSTEP;
  localparam int Z_W     = ((COORD_WIDTH > REG_W + 1) ? COORD_WIDTH : REG_W + 1) + 3;

  localparam int CFG_IW  = 2;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [REG_W-1:0] HSPEED_RST  = 16'd12800;
  localparam logic [REG_W-1:0] LHEIGHT_RST = 16'd5120;
  localparam logic [REG_W-1:0] LSPEED_RST  = 16'd5120;

  typedef enum logic [CFG_IW-1:0] {
    REG_HSPEED  = 2'd0,
    REG_LHEIGHT = 2'd1,
    REG_LSPEED  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0] hspeed;
    logic [REG_W-1:0] lheight;
    logic [REG_W-1:0] lspeed;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [COORD_WIDTH-1:0] cz;
    logic signed [COORD_WIDTH-1:0] gx;
    logic signed [COORD_WIDTH-1:0] gy;
    logic signed [COORD_WIDTH-1:0] gz;
    logic [TIME_W-1:0]             t;
    logic [MAG_W-1:0]              adx;
    logic [MAG_W-1:0]              ady;
    logic                          dx_neg;
    logic                          dy_neg;
    logic [LIFT_AW-1:0]            absl;
  } item_t;

  typedef struct packed {
    item_t             it;
    logic [MOVE_W-1:0] mz;
    logic              far;
    logic              zero;
    logic              c1;
    logic              c2;
  } mid_t;

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
    input logic signed [Z_W-1:0] v
  );
    logic signed [Z_W-1:0] hi;
    logic signed [Z_W-1:0] lo;
    hi = {{(Z_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[COORD_WIDTH-1:0];
    end else if (v < lo) begin
      return lo[COORD_WIDTH-1:0];
    end
    return v[COORD_WIDTH-1:0];
  endfunction

endpackage

// ===== design/lfms_div.sv =====
// ----------------------------------------------------------------------------
// lfms_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module lfms_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [lfms_pkg::NUM_W-1:0] num,
  input  logic [lfms_pkg::DEN_W-1:0] den,
  output logic [lfms_pkg::NSTEP-1:0] quo
);
  import lfms_pkg::*;

  logic [REM_W-1:0] r_r  [NSTEP];
  logic [DEN_W-1:0] d_r  [NSTEP];
  logic [NSTEP-1:0] q_r  [NSTEP];
  logic [REM_W-1:0] r_in [NSTEP];
  logic [DEN_W-1:0] d_in [NSTEP];
  logic [NSTEP-1:0] q_in [NSTEP];
  logic [REM_W-1:0] sh   [NSTEP];
  logic             ge   [NSTEP];

  always_comb begin
    r_in[0] = REM_W'(num);
    d_in[0] = den;
    q_in[0] = '0;
    for (int k = 1; k < NSTEP; k++) begin
      r_in[k] = r_r[k-1];
      d_in[k] = d_r[k-1];
      q_in[k] = q_r[k-1];
    end
    for (int k = 0; k < NSTEP; k++) begin
      sh[k] = REM_W'(d_in[k]) << (NSTEP - 1 - k);
      ge[k] = r_in[k] >= sh[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NSTEP; k++) begin
        r_r[k] <= ge[k] ? r_in[k] - sh[k] : r_in[k];
        d_r[k] <= d_in[k];
        q_r[k] <= ge[k] ? (q_in[k] | (NSTEP'(1) << (NSTEP - 1 - k))) : q_in[k];
      end
    end
  end

  assign quo = q_r[NSTEP-1];

endmodule

// ===== design/lfms_sqrt.sv =====
// ----------------------------------------------------------------------------
// lfms_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module lfms_sqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [lfms_pkg::RAD_W-1:0] rad,
  output logic [lfms_pkg::NSTEP-1:0] root
);
  import lfms_pkg::*;

  logic [RAD_W-1:0] op_r   [NSTEP];
  logic [RAD_W-1:0] res_r  [NSTEP];
  logic [RAD_W-1:0] op_in  [NSTEP];
  logic [RAD_W-1:0] res_in [NSTEP];
  logic [RAD_W-1:0] one    [NSTEP];
  logic [RAD_W-1:0] trial  [NSTEP];
  logic             ge     [NSTEP];

  always_comb begin
    op_in[0]  = rad;
    res_in[0] = '0;
    for (int k = 1; k < NSTEP; k++) begin
      op_in[k]  = op_r[k-1];
      res_in[k] = res_r[k-1];
    end
    for (int k = 0; k < NSTEP; k++) begin
      one[k]   = RAD_W'(1) << (2 * (NSTEP - 1 - k));
      trial[k] = res_in[k] + one[k];
      ge[k]    = op_in[k] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NSTEP; k++) begin
        op_r[k]  <= ge[k] ? op_in[k] - trial[k] : op_in[k];
        res_r[k] <= ge[k] ? (res_in[k] >> 1) + one[k] : res_in[k] >> 1;
      end
    end
  end

  assign root = res_r[NSTEP-1][NSTEP-1:0];

endmodule

// ===== design/lfms_front.sv =====
// ----------------------------------------------------------------------------
// lfms_front
// input stage: takes an item, forms axis differences and the lift span
// ----------------------------------------------------------------------------
module lfms_front (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  lfms_pkg::cfg_t                          cfg,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [lfms_pkg::COORD_WIDTH-1:0] in_cur_x,
  input  logic signed [lfms_pkg::COORD_WIDTH-1:0] in_cur_y,
  input  logic signed [lfms_pkg::COORD_WIDTH-1:0] in_cur_z,
  input  logic signed [lfms_pkg::COORD_WIDTH-1:0] in_goal_x,
  input  logic signed [lfms_pkg::COORD_WIDTH-1:0] in_goal_y,
  input  logic signed [lfms_pkg::COORD_WIDTH-1:0] in_goal_z,
  input  logic [lfms_pkg::TIME_W-1:0]             in_time_step_us,
  output logic                                    f_valid,
  input  logic                                    f_ready,
  output lfms_pkg::item_t                         f_item
);
  import lfms_pkg::*;

  logic signed [DIFF_W-1:0]  dx;
  logic signed [DIFF_W-1:0]  dy;
  logic signed [DIFF_W-1:0]  dz;
  logic signed [LIFT_SW-1:0] lift;
  item_t                     item_nxt;
  item_t                     item_r;
  logic                      vld_r;

  assign dx   = DIFF_W'(in_goal_x) - DIFF_W'(in_cur_x);
  assign dy   = DIFF_W'(in_goal_y) - DIFF_W'(in_cur_y);
  assign dz   = DIFF_W'(in_goal_z) - DIFF_W'(in_cur_z);
  assign lift = LIFT_SW'(dz) + LIFT_SW'({1'b0, cfg.lheight});

  always_comb begin
    item_nxt.cx     = in_cur_x;
    item_nxt.cy     = in_cur_y;
    item_nxt.cz     = in_cur_z;
    item_nxt.gx     = in_goal_x;
    item_nxt.gy     = in_goal_y;
    item_nxt.gz     = in_goal_z;
    item_nxt.t      = in_time_step_us;
    item_nxt.dx_neg = dx[DIFF_W-1];
    item_nxt.dy_neg = dy[DIFF_W-1];
    item_nxt.adx    = dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    item_nxt.ady    = dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
    item_nxt.absl   = lift[LIFT_SW-1] ? LIFT_AW'(-lift) : LIFT_AW'(lift);
  end

  assign in_ready = !vld_r || f_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

  assign f_valid = vld_r;
  assign f_item  = item_r;

endmodule

// ===== design/lfms_fifo.sv =====
// ----------------------------------------------------------------------------
// lfms_fifo
// short queue between the input stage and the arithmetic pipeline
// ----------------------------------------------------------------------------
module lfms_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  lfms_pkg::item_t wr_item,
  output logic            rd_valid,
  input  logic            rd_ready,
  output lfms_pkg::item_t rd_item
);
  import lfms_pkg::*;

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r;
  logic [QPTR_W-1:0] rp_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push;
  logic              pop;

  assign wr_ready = cnt_r != QCNT_W'(QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_item  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

endmodule

// ===== design/lfms_back.sv =====
// ----------------------------------------------------------------------------
// lfms_back
// arithmetic pipeline: distance, step limits, lift scaling and final moves
// ----------------------------------------------------------------------------
module lfms_back (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  lfms_pkg::cfg_t                          cfg,
  input  logic                                    b_valid,
  output logic                                    b_ready,
  input  lfms_pkg::item_t                         b_item,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [lfms_pkg::COORD_WIDTH-1:0] out_next_x,
  output logic signed [lfms_pkg::COORD_WIDTH-1:0] out_next_y,
  output logic signed [lfms_pkg::COORD_WIDTH-1:0] out_next_z
);
  import lfms_pkg::*;

  logic               adv;
  logic [2*REG_W-1:0] lhls_r;
  logic [2*REG_W-1:0] lhhs_r;

  // squares and speed-time products
  logic               v1_r;
  item_t              it1_r;
  logic [SQ_W-1:0]    sqx1_r;
  logic [SQ_W-1:0]    sqy1_r;
  logic [PROD_W-1:0]  pm1_r;
  logic [PROD_W-1:0]  pz1_r;

  // radicand and step limits
  logic               v2_r;
  item_t              it2_r;
  logic [RAD_W-1:0]   rad2_r;
  logic [MOVE_W-1:0]  pm2_r;
  logic [MOVE_W-1:0]  pz2_r;

  logic               vd_r  [NSTEP];
  item_t              itd_r [NSTEP];
  logic [MOVE_W-1:0]  mmd_r [NSTEP];
  logic [MOVE_W-1:0]  mzd_r [NSTEP];
  logic [NSTEP-1:0]   dist_w;
  logic [NSTEP-1:0]   mm_w;
  logic [NSTEP-1:0]   mz_w;

  // products feeding the divider bank
  logic               v3_r;
  item_t              it3_r;
  logic [DIST_W-1:0]  dist3_r;
  logic [MOVE_W-1:0]  mz3_r;
  logic [PX_W-1:0]    px3_r;
  logic [PX_W-1:0]    py3_r;
  logic [RUN_W-1:0]   run3_r;
  logic [UP_W-1:0]    up3_r;
  logic [HN_W-1:0]    hn3_r;
  logic               far3_r;
  logic               zero3_r;

  mid_t               mid_nxt;
  logic               vm_r  [NSTEP];
  mid_t               mdd_r [NSTEP];
  logic [NSTEP-1:0]   qx_w;
  logic [NSTEP-1:0]   qy_w;
  logic [NSTEP-1:0]   qh1_w;
  logic [NSTEP-1:0]   qh2_w;

  mid_t                          m;
  logic signed [Z_W-1:0]         qx;
  logic signed [Z_W-1:0]         qy;
  logic signed [Z_W-1:0]         nx;
  logic signed [Z_W-1:0]         ny;
  logic signed [Z_W-1:0]         aim;
  logic signed [Z_W-1:0]         czw;
  logic signed [Z_W-1:0]         mzw;
  logic signed [Z_W-1:0]         gap;
  logic signed [Z_W-1:0]         stp;
  logic signed [Z_W-1:0]         nz;
  logic [REG_W-1:0]              hv;
  logic                          out_v_r;
  logic signed [COORD_WIDTH-1:0] nx_r;
  logic signed [COORD_WIDTH-1:0] ny_r;
  logic signed [COORD_WIDTH-1:0] nz_r;

  assign adv     = !out_v_r || out_ready;
  assign b_ready = adv;

  always_ff @(posedge clk) begin
    lhls_r <= (2*REG_W)'(cfg.lheight) * (2*REG_W)'(cfg.lspeed);
    lhhs_r <= (2*REG_W)'(cfg.lheight) * (2*REG_W)'(cfg.hspeed);
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      out_v_r <= 1'b0;
      for (int k = 0; k < NSTEP; k++) begin
        vd_r[k] <= 1'b0;
        vm_r[k] <= 1'b0;
      end
    end else if (adv) begin
      v1_r    <= b_valid;
      v2_r    <= v1_r;
      vd_r[0] <= v2_r;
      for (int k = 1; k < NSTEP; k++) begin
        vd_r[k] <= vd_r[k-1];
        vm_r[k] <= vm_r[k-1];
      end
      v3_r    <= vd_r[NSTEP-1];
      vm_r[0] <= v3_r;
      out_v_r <= vm_r[NSTEP-1];
    end
  end

  // data path
  always_ff @(posedge clk) begin
    if (adv) begin
      it1_r  <= b_item;
      sqx1_r <= SQ_W'(b_item.adx) * SQ_W'(b_item.adx);
      sqy1_r <= SQ_W'(b_item.ady) * SQ_W'(b_item.ady);
      pm1_r  <= PROD_W'(cfg.hspeed) * PROD_W'(b_item.t);
      pz1_r  <= PROD_W'(cfg.lspeed) * PROD_W'(b_item.t);

      // per-second speed times us, divided by 10^6 with a reciprocal
      it2_r  <= it1_r;
      rad2_r <= RAD_W'(sqx1_r) + RAD_W'(sqy1_r);
      pm2_r  <= MOVE_W'((RCP_PW'(pm1_r[PROD_W-1:US_SH]) * RCP_PW'(US_RCP)) >> US_RCP_K);
      pz2_r  <= MOVE_W'((RCP_PW'(pz1_r[PROD_W-1:US_SH]) * RCP_PW'(US_RCP)) >> US_RCP_K);

      // limits ride alongside the square root
      itd_r[0] <= it2_r;
      mmd_r[0] <= pm2_r;
      mzd_r[0] <= pz2_r;
      for (int k = 1; k < NSTEP; k++) begin
        itd_r[k] <= itd_r[k-1];
        mmd_r[k] <= mmd_r[k-1];
        mzd_r[k] <= mzd_r[k-1];
        mdd_r[k] <= mdd_r[k-1];
      end

      it3_r   <= itd_r[NSTEP-1];
      dist3_r <= dist_w[DIST_W-1:0];
      mz3_r   <= mz_w[MOVE_W-1:0];
      px3_r   <= PX_W'(itd_r[NSTEP-1].adx) * PX_W'(mm_w[MOVE_W-1:0]);
      py3_r   <= PX_W'(itd_r[NSTEP-1].ady) * PX_W'(mm_w[MOVE_W-1:0]);
      run3_r  <= RUN_W'(dist_w[DIST_W-1:0]) * RUN_W'(cfg.lspeed);
      up3_r   <= (UP_W'(itd_r[NSTEP-1].absl) * UP_W'(cfg.hspeed)) << 1;
      hn3_r   <= HN_W'(lhls_r) * HN_W'(dist_w[DIST_W-1:0]);
      far3_r  <= mm_w[MOVE_W-1:0] >= dist_w[DIST_W-1:0];
      zero3_r <= dist_w[DIST_W-1:0] == '0;

      mdd_r[0] <= mid_nxt;

      nx_r <= sat_coord(nx);
      ny_r <= sat_coord(ny);
      nz_r <= sat_coord(nz);
    end
  end

  lfms_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (rad2_r),
    .root (dist_w)
  );

  assign mm_w = NSTEP'(mmd_r[NSTEP-1]);
  assign mz_w = NSTEP'(mzd_r[NSTEP-1]);

  always_comb begin
    mid_nxt.it   = it3_r;
    mid_nxt.mz   = mz3_r;
    mid_nxt.far  = far3_r;
    mid_nxt.zero = zero3_r;
    mid_nxt.c1   = up3_r > UP_W'(run3_r);
    mid_nxt.c2   = lhhs_r > run3_r;
  end

  lfms_div u_div_x (
    .clk (clk),
    .en  (adv),
    .num (NUM_W'(px3_r)),
    .den (DEN_W'(dist3_r)),
    .quo (qx_w)
  );

  lfms_div u_div_y (
    .clk (clk),
    .en  (adv),
    .num (NUM_W'(py3_r)),
    .den (DEN_W'(dist3_r)),
    .quo (qy_w)
  );

  lfms_div u_div_h1 (
    .clk (clk),
    .en  (adv),
    .num (hn3_r),
    .den (up3_r),
    .quo (qh1_w)
  );

  lfms_div u_div_h2 (
    .clk (clk),
    .en  (adv),
    .num (NUM_W'(run3_r)),
    .den (DEN_W'(cfg.hspeed)),
    .quo (qh2_w)
  );

  // final moves
  always_comb begin
    m   = mdd_r[NSTEP-1];
    qx  = Z_W'(qx_w[MOVE_W-1:0]);
    qy  = Z_W'(qy_w[MOVE_W-1:0]);
    if (m.far) begin
      nx = Z_W'(m.it.gx);
      ny = Z_W'(m.it.gy);
    end else begin
      nx = m.it.dx_neg ? Z_W'(m.it.cx) - qx : Z_W'(m.it.cx) + qx;
      ny = m.it.dy_neg ? Z_W'(m.it.cy) - qy : Z_W'(m.it.cy) + qy;
    end
    if (m.zero) begin
      hv = '0;
    end else if (m.c2) begin
      hv = qh2_w[REG_W-1:0];
    end else if (m.c1) begin
      hv = qh1_w[REG_W-1:0];
    end else begin
      hv = cfg.lheight;
    end
    aim = Z_W'(m.it.gz) + Z_W'(hv);
    czw = Z_W'(m.it.cz);
    mzw = Z_W'(m.mz);
    gap = (czw < aim) ? aim - czw : czw - aim;
    stp = (mzw < gap) ? mzw : gap;
    nz  = (czw < aim) ? czw + stp : czw - stp;
  end

  assign out_valid  = out_v_r;
  assign out_next_x = nx_r;
  assign out_next_y = ny_r;
  assign out_next_z = nz_r;

endmodule

// ===== design/leg_foot_motion_step_top.sv =====
// ----------------------------------------------------------------------------
// leg_foot_motion_step_top
// one control tick of foot motion toward a goal, with lift over the travel
// ----------------------------------------------------------------------------
// usage
//   in channel: valid/ready, current and goal position plus elapsed time in us
//   out channel: valid/ready, next x/y/z, saturated to the coordinate range
//   cfg port: cfg_we with cfg_index/cfg_data, write only, takes effect at once;
//     write only while no item is in flight
//   throughput: one item per cycle, no state kept between items
//   latency: 2*NSTEP + 5 cycles from in transfer to out_valid, 47 cycles at
//     20-bit coordinates; set by the one-bit-per-stage square root and the
//     bank of pipelined dividers that follows it
//   stall: when out_ready is low the whole pipeline holds and the queue
//     behind it fills, in_ready falls only once the input stage and queue
//     are full; the result register keeps its value until the transfer
//   reset: synchronous active-low rst_n empties the pipeline and queue and
//     loads the speed and lift registers with their defaults
// ----------------------------------------------------------------------------
module leg_foot_motion_step_top (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [lfms_pkg::COORD_WIDTH-1:0] in_cur_x,
  input  logic signed [lfms_pkg::COORD_WIDTH-1:0] in_cur_y,
  input  logic signed [lfms_pkg::COORD_WIDTH-1:0] in_cur_z,
  input  logic signed [lfms_pkg::COORD_WIDTH-1:0] in_goal_x,
  input  logic signed [lfms_pkg::COORD_WIDTH-1:0] in_goal_y,
  input  logic signed [lfms_pkg::COORD_WIDTH-1:0] in_goal_z,
  input  logic [lfms_pkg::TIME_W-1:0]             in_time_step_us,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [lfms_pkg::COORD_WIDTH-1:0] out_next_x,
  output logic signed [lfms_pkg::COORD_WIDTH-1:0] out_next_y,
  output logic signed [lfms_pkg::COORD_WIDTH-1:0] out_next_z,
  input  logic                                    cfg_we,
  input  logic [lfms_pkg::CFG_IW-1:0]             cfg_index,
  input  logic [lfms_pkg::REG_W-1:0]              cfg_data
);
  import lfms_pkg::*;

  cfg_t  cfg_r;
  cfg_t  cfg_nxt;
  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  b_valid;
  logic  b_ready;
  item_t b_item;

  // register decode, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_HSPEED:  cfg_nxt.hspeed  = cfg_data;
        REG_LHEIGHT: cfg_nxt.lheight = cfg_data;
        REG_LSPEED:  cfg_nxt.lspeed  = cfg_data;
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hspeed  <= HSPEED_RST;
      cfg_r.lheight <= LHEIGHT_RST;
      cfg_r.lspeed  <= LSPEED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: registers the item and forms differences and the lift span
  lfms_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cur_x        (in_cur_x),
    .in_cur_y        (in_cur_y),
    .in_cur_z        (in_cur_z),
    .in_goal_x       (in_goal_x),
    .in_goal_y       (in_goal_y),
    .in_goal_z       (in_goal_z),
    .in_time_step_us (in_time_step_us),
    .f_valid         (f_valid),
    .f_ready         (f_ready),
    .f_item          (f_item)
  );

  // queue decouples the front from pipeline stalls
  lfms_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_item  (b_item)
  );

  // back: distance, limits, lift scaling and the output register
  lfms_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .b_valid    (b_valid),
    .b_ready    (b_ready),
    .b_item     (b_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_next_x (out_next_x),
    .out_next_y (out_next_y),
    .out_next_z (out_next_z)
  );

endmodule

// ===== design/lfms_chk.sv =====
// ----------------------------------------------------------------------------
// lfms_chk
// port-level checks for the foot motion step block
// ----------------------------------------------------------------------------
module lfms_chk (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    in_ready,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic signed [lfms_pkg::COORD_WIDTH-1:0] out_next_x,
  input logic signed [lfms_pkg::COORD_WIDTH-1:0] out_next_y,
  input logic signed [lfms_pkg::COORD_WIDTH-1:0] out_next_z
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_x) &&
      $stable(out_next_y) && $stable(out_next_z))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // reset leaves the input stage and queue free
  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind leg_foot_motion_step_top lfms_chk u_chk (.*);

// ===== tb/tb_leg_foot_motion_step_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_leg_foot_motion_step_top
// streams foot positions through the motion step block under random idling
// and back-pressure, and checks each next position against an integer model
// ----------------------------------------------------------------------------
module tb_leg_foot_motion_step_top;
  import lfms_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int LAT = 2 * NSTEP + 6;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } pos_t;

  typedef struct {
    logic signed [CW-1:0] cx, cy, cz, gx, gy, gz;
    logic [TIME_W-1:0]    t;
  } step_in_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] in_cur_x = '0, in_cur_y = '0, in_cur_z = '0;
  logic signed [CW-1:0] in_goal_x = '0, in_goal_y = '0, in_goal_z = '0;
  logic [TIME_W-1:0] in_time_step_us = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CW-1:0] out_next_x, out_next_y, out_next_z;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  // model copy of the configuration registers
  longint unsigned m_hspeed, m_lheight, m_lspeed;

  pos_t expected_pos[$];
  int   mismatches = 0;
  bit   quiet = 1'b0;      // no idling in the last part of the run
  int   hold_off = 0;      // receiver long stall request, in cycles

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  leg_foot_motion_step_top dut (.*);

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------
  function automatic longint isqrt(longint unsigned s);
    longint unsigned r, c;
    r = 0;
    for (int b = 35; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= 128'(s)) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] clamp(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  function automatic pos_t next_foot_pos(step_in_t s);
    longint cx, cy, cz, gx, gy, gz, dx, dy, nx, ny, nz, aim, lz;
    longint unsigned adx, ady, span, mmove, mz, absl, run, up, h, gap;
    logic [127:0] num;
    pos_t p;
    cx = s.cx; cy = s.cy; cz = s.cz; gx = s.gx; gy = s.gy; gz = s.gz;
    dx = gx - cx; dy = gy - cy;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    span = isqrt(adx * adx + ady * ady);
    mmove = m_hspeed * s.t / 1000000;
    mz = m_lspeed * s.t / 1000000;
    nx = cx; ny = cy; nz = cz; h = 0;
    if (span != 0) begin
      lz = gz - cz + longint'(m_lheight);
      absl = lz < 0 ? -lz : lz;
      run = span * m_lspeed;
      up = 2 * absl * m_hspeed;
      if (mmove >= span) begin
        nx = gx; ny = gy;
      end else begin
        nx = dx < 0 ? cx - longint'(adx * mmove / span) : cx + longint'(adx * mmove / span);
        ny = dy < 0 ? cy - longint'(ady * mmove / span) : cy + longint'(ady * mmove / span);
      end
      h = m_lheight;
      if (up > run) begin
        num = 128'(m_lheight * m_lspeed) * 128'(span);
        h = longint'(num / 128'(up));
      end
      if (m_lheight * m_hspeed > run) h = run / m_hspeed;
    end
    aim = gz + longint'(h);
    if (cz < aim) begin
      gap = aim - cz;
      nz = cz + longint'(mz < gap ? mz : gap);
    end else if (cz > aim) begin
      gap = cz - aim;
      nz = cz - longint'(mz < gap ? mz : gap);
    end
    p.x = clamp(nx); p.y = clamp(ny); p.z = clamp(nz);
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // shared stimulus helpers
  // --------------------------------------------------------------------------
  // valid stays high from one item to the next unless an idle burst comes
  task automatic send_step(step_in_t s);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_cur_x <= s.cx; in_cur_y <= s.cy; in_cur_z <= s.cz;
    in_goal_x <= s.gx; in_goal_y <= s.gy; in_goal_z <= s.gz;
    in_time_step_us <= s.t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transfer happens at this edge; predict with the current registers
    expected_pos.push_back(next_foot_pos(s));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_pos.size() != 0) @(negedge clk);
    repeat (LAT + 4) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HSPEED:  m_hspeed = val;
      REG_LHEIGHT: m_lheight = val;
      REG_LSPEED:  m_lspeed = val;
      default: ;
    endcase
  endtask

  function automatic logic signed [CW-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(CW - 1){1'b1}}};
      1: return {1'b1, {(CW - 1){1'b0}}};
      2: return CW'($urandom);
      default: return CW'($signed($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  function automatic step_in_t rnd_step();
    step_in_t s;
    s.cx = rnd_coord(); s.cy = rnd_coord(); s.cz = rnd_coord();
    // mostly goals near the foot so that the lift path is exercised
    if ($urandom_range(0, 3) != 0) begin
      s.gx = s.cx + CW'($signed($urandom_range(0, 8000)) - 4000);
      s.gy = s.cy + CW'($signed($urandom_range(0, 8000)) - 4000);
      s.gz = s.cz + CW'($signed($urandom_range(0, 8000)) - 4000);
    end else begin
      s.gx = rnd_coord(); s.gy = rnd_coord(); s.gz = rnd_coord();
    end
    if ($urandom_range(0, 9) == 0) begin
      s.gx = s.cx; s.gy = s.cy;
    end
    case ($urandom_range(0, 4))
      0: s.t = TIME_W'($urandom);
      1: s.t = '0;
      default: s.t = TIME_W'($urandom_range(0, 200000));
    endcase
    return s;
  endfunction

  function automatic step_in_t mk(longint cx, cy, cz, gx, gy, gz, longint unsigned t);
    step_in_t s;
    s.cx = CW'(cx); s.cy = CW'(cy); s.cz = CW'(cz);
    s.gx = CW'(gx); s.gy = CW'(gy); s.gz = CW'(gz);
    s.t = TIME_W'(t);
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // result checker and receiver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pos_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pos.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d %0d %0d",
                                       out_next_x, out_next_y, out_next_z);
      end else begin
        e = expected_pos.pop_front();
        if (e.x !== out_next_x || e.y !== out_next_y || e.z !== out_next_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     e.x, e.y, e.z, out_next_x, out_next_y, out_next_z);
        end
      end
    end
  end

  // receiver stalls: random bursts, plus one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    longint mx, mn;
    mx = (64'sd1 <<< (CW - 1)) - 1;
    mn = -mx - 1;
    send_step(mk(0, 0, 0, 0, 0, 0, 0));                 // all zero
    send_step(mk(100, 100, 0, 100, 100, 500, 100000));  // zero distance
    send_step(mk(0, 0, 0, 1000, 0, 0, 0));              // zero time step
    send_step(mk(0, 0, 0, 1000, -700, 0, 100000));      // move reaches the goal
    send_step(mk(0, 0, 0, 10, 10, 0, 1000000));         // lands on goal
    send_step(mk(mx, mx, mx, mn, mn, mn, 1048575));     // extremes
    send_step(mk(mn, mn, mn, mx, mx, mx, 1048575));
    send_step(mk(0, 0, mx, 30000, 0, mx, 1048575));     // z saturates high
    send_step(mk(0, 0, 0, 200000, 0, -5120, 500000));   // lift span of zero
    send_step(mk(-5, 3, 9, 5, -3, -9, 20000));
    drain();
  endtask

  task automatic test_config_corners();
    logic [REG_W-1:0] vals[4] = '{16'd0, 16'd1, 16'hffff, 16'd777};
    foreach (vals[i]) begin
      write_reg(REG_HSPEED, vals[i]);
      write_reg(REG_LHEIGHT, vals[3 - i]);
      write_reg(REG_LSPEED, vals[(i + 1) % 4]);
      repeat (15) send_step(rnd_step());
      drain();
    end
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 250 == 0) begin
        drain();
        write_reg(REG_HSPEED, REG_W'($urandom_range(1, 65535)));
        write_reg(REG_LHEIGHT, REG_W'($urandom));
        write_reg(REG_LSPEED, REG_W'($urandom_range(1, 65535)));
      end
      send_step(rnd_step());
    end
    drain();
  endtask

  task automatic test_backpressure();
    // long receiver stall while items keep coming, so input stalls
    @(negedge clk);
    hold_off = 120;
    repeat (80) send_step(rnd_step());
    drain();
  endtask

  task automatic test_streaming();
    quiet = 1'b1;
    write_reg(REG_HSPEED, HSPEED_RST);
    write_reg(REG_LHEIGHT, LHEIGHT_RST);
    write_reg(REG_LSPEED, LSPEED_RST);
    repeat (150) send_step(rnd_step());
    drain();
  endtask

  initial begin
    m_hspeed = HSPEED_RST; m_lheight = LHEIGHT_RST; m_lspeed = LSPEED_RST;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_config_corners();
    test_backpressure();
    test_random(850);
    test_streaming();
    if (mismatches == 0 && expected_pos.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
design/lfms_pkg.sv
design/lfms_div.sv
design/lfms_sqrt.sv
design/lfms_front.sv
design/lfms_fifo.sv
design/lfms_back.sv
design/leg_foot_motion_step_top.sv
design/lfms_chk.sv
tb/tb_leg_foot_motion_step_top.sv
